>>> rtl/smvm_pkg.sv
// Shared types and constants for the sparse matrix-vector multiply core.
// No dependencies; smvm_mac, smvm_out_fifo and the core import this package.
`default_nettype none

package smvm_pkg;

    // Input word kinds carried on the slave tuser field
    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_ENTRY     = 2'd1,
        CMD_EMPTY_ROW = 2'd2
    } t_cmd;

    localparam int INDEX_W   = 10;
    localparam int VALUE_W   = 32;
    localparam int ROW_W     = 16;
    localparam int SUM_W     = 64;
    // Wide enough to compare an index against any vector depth up to 65536
    localparam int IDX_EXT_W = 17;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Control of one word as it moves down the pipeline
    typedef struct packed {
        t_cmd cmd;
        logic row_end;
        logic in_range;
    } t_op;

    // Pipeline occupancy reported to the input side
    typedef struct packed {
        logic b_valid;
        logic c_valid;
    } t_pipe_status;

    typedef struct packed {
        logic                    saturated;
        logic signed [SUM_W-1:0] row_sum;
        logic [ROW_W-1:0]        row_number;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/smvm_vec_mem.sv
// Dense vector store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module smvm_vec_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [31:0]       i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [31:0]            o_rdata
);

    logic [31:0] r_mem [DEPTH];

    // Write the loaded element
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read every cycle into a registered output
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/smvm_mac.sv
// Multiply stage and saturating row accumulator with row counter.
// Depends on smvm_pkg; fed by the vector store read data.
`default_nettype none

module smvm_mac (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire smvm_pkg::t_op               i_op,
    input  wire logic [smvm_pkg::VALUE_W-1:0] i_value,
    input  wire logic [31:0]                 i_mem_rdata,
    output logic                             o_push,
    output smvm_pkg::t_result                o_result,
    output smvm_pkg::t_pipe_status           o_status
);
    import smvm_pkg::*;

    // Stage B: word waiting for its vector element
    logic                      r_b_valid;
    t_op                       r_b_op;
    logic signed [VALUE_W-1:0] r_b_value;

    // Stage C: product waiting to be accumulated
    logic                    r_c_valid;
    t_op                     r_c_op;
    logic signed [SUM_W-1:0] r_c_prod;

    // Row state
    logic signed [SUM_W-1:0] r_acc;
    logic                    r_ovf;
    logic [ROW_W-1:0]        r_row;
    logic signed [SUM_W-1:0] n_acc;
    logic                    n_ovf;
    logic [ROW_W-1:0]        n_row;

    logic signed [31:0]      w_vec;
    logic signed [SUM_W-1:0] w_prod;
    logic signed [SUM_W:0]   w_sum;
    logic signed [SUM_W-1:0] w_sat;
    logic                    w_sat_hit;

    // Hold control of stages B and C
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_b_valid <= i_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Advance payload; out-of-range columns multiply by zero
    assign w_vec  = r_b_op.in_range ? signed'(i_mem_rdata) : 32'sd0;
    assign w_prod = r_b_value * w_vec;

    always_ff @(posedge i_clk) begin
        r_b_op    <= i_op;
        r_b_value <= signed'(i_value);
        r_c_op    <= r_b_op;
        r_c_prod  <= w_prod;
    end

    // Saturating add of the product into the row sum
    assign w_sum     = {r_acc[SUM_W-1], r_acc} + {r_c_prod[SUM_W-1], r_c_prod};
    assign w_sat_hit = w_sum[SUM_W] != w_sum[SUM_W-1];
    assign w_sat     = !w_sat_hit ? w_sum[SUM_W-1:0] :
                       (w_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}});

    // Update the row state and emit finished rows
    always_comb begin
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_row    = r_row;
        o_push   = 1'b0;
        o_result = '{saturated: r_ovf, row_sum: r_acc, row_number: r_row};
        if (r_c_valid) begin
            case (r_c_op.cmd)
                CMD_LOAD: begin
                    n_acc = '0;
                    n_ovf = 1'b0;
                    n_row = '0;
                end
                CMD_ENTRY: begin
                    if (r_c_op.row_end) begin
                        o_push   = 1'b1;
                        o_result = '{saturated: r_ovf | w_sat_hit, row_sum: w_sat,
                                     row_number: r_row};
                        n_acc    = '0;
                        n_ovf    = 1'b0;
                        n_row    = r_row + 16'd1;
                    end else begin
                        n_acc = w_sat;
                        n_ovf = r_ovf | w_sat_hit;
                    end
                end
                CMD_EMPTY_ROW: begin
                    o_push = 1'b1;
                    n_acc  = '0;
                    n_ovf  = 1'b0;
                    n_row  = r_row + 16'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_row <= '0;
        end else begin
            r_acc <= n_acc;
            r_ovf <= n_ovf;
            r_row <= n_row;
        end
    end

    assign o_status = '{b_valid: r_b_valid, c_valid: r_c_valid};

    // A finished row leaves a clean accumulator behind
    a_clear_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_acc == '0) && !r_ovf)
        else $error("accumulator not cleared after row end");

    // Row numbers advance by one per emitted row
    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_row == $past(r_row) + 16'd1)
        else $error("row counter did not advance");

    // A load restarts row numbering
    a_load_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_op.cmd == CMD_LOAD) |=> r_row == '0)
        else $error("load did not reset row counter");

endmodule

`default_nettype wire

>>> rtl/smvm_out_fifo.sv
// Small result queue that decouples the accumulator from the output stream.
// Depends on smvm_pkg for the result type and queue size.
`default_nettype none

module smvm_out_fifo (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire smvm_pkg::t_result             i_result,
    input  wire logic                          i_pop,
    output logic                               o_valid,
    output smvm_pkg::t_result                  o_result,
    output logic [smvm_pkg::FIFO_CNT_W-1:0]    o_count
);
    import smvm_pkg::*;

    t_result               r_buf [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_pop;

    assign w_pop = i_pop && (r_count != '0);

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_result;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid  = r_count != '0;
    assign o_result = r_buf[r_rd_ptr];
    assign o_count  = r_count;

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    // Occupancy stays within the queue size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

endmodule

`default_nettype wire

>>> rtl/sparse_matrix_vector_multiply_core.sv
// Sparse matrix-vector multiply core, compressed-row order, signed integers.
// Load vector elements with tuser = load, then stream nonzero entries
// (tuser = entry, tdata = column and value, tlast on the last entry of a row)
// or tuser = empty row. Each finished row comes out as its row number, its
// 64-bit saturated dot product and a saturation flag. Any load clears the
// partial sum and restarts row numbering at zero. The core takes one word
// per clock cycle while tready is high: the 64-bit saturating add into the
// row accumulator is combinational, and the vector store has one read and
// one write port. A row result raises the output tvalid once its closing
// word has passed stages B and C and entered the result queue. A four-word
// result queue lets input continue while results wait; tready falls only
// when the queue plus words in flight would exceed it. Reading a vector
// element that was never loaded returns undefined data.
// Depends on smvm_pkg, smvm_vec_mem, smvm_mac and smvm_out_fifo.
`default_nettype none

module sparse_matrix_vector_multiply_core #(
    parameter int VECTOR_DEPTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input words
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,  // [9:0] index, [41:10] value, rest zero
    input  wire logic [1:0]  i_s_axis_tuser,  // [1:0] cmd
    input  wire logic        i_s_axis_tlast,  // row_end
    // Row results
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [79:0]      o_m_axis_tdata,  // [15:0] row_number, [79:16] row_sum
    output logic [0:0]       o_m_axis_tuser   // [0] saturated
);
    import smvm_pkg::*;

    localparam int ADDR_W = (VECTOR_DEPTH > 2) ? $clog2(VECTOR_DEPTH) : 1;

    logic                  w_s_fire;
    t_cmd                  w_cmd;
    logic [INDEX_W-1:0]    w_index;
    logic [VALUE_W-1:0]    w_value;
    logic [IDX_EXT_W-1:0]  w_index_ext;
    logic                  w_in_range;
    logic [ADDR_W-1:0]     w_addr;
    t_op                   w_op;
    logic [31:0]           w_rdata;
    logic                  w_push;
    t_result               w_push_result;
    t_pipe_status          w_status;
    logic                  w_q_valid;
    t_result               w_q_result;
    logic [FIFO_CNT_W-1:0] w_q_count;
    logic [FIFO_CNT_W-1:0] w_reserved;

    // Unpack the input word
    assign w_cmd       = t_cmd'(i_s_axis_tuser);
    assign w_index     = i_s_axis_tdata[INDEX_W-1:0];
    assign w_value     = i_s_axis_tdata[INDEX_W +: VALUE_W];
    assign w_index_ext = IDX_EXT_W'(w_index);
    assign w_in_range  = w_index_ext < IDX_EXT_W'(VECTOR_DEPTH);
    assign w_addr      = w_index_ext[ADDR_W-1:0];
    assign w_op        = '{cmd: w_cmd, row_end: i_s_axis_tlast, in_range: w_in_range};

    // Accept while the queue has room for every word in flight
    assign w_reserved = w_q_count + FIFO_CNT_W'(w_status.b_valid)
                                  + FIFO_CNT_W'(w_status.c_valid);
    assign o_s_axis_tready = w_reserved < FIFO_CNT_W'(FIFO_DEPTH);
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;

    smvm_vec_mem #(
        .DEPTH  (VECTOR_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_vec_mem (
        .i_clk   (i_clk),
        .i_we    (w_s_fire && w_cmd == CMD_LOAD && w_in_range),
        .i_waddr (w_addr),
        .i_wdata (w_value),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    smvm_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_s_fire),
        .i_op        (w_op),
        .i_value     (w_value),
        .i_mem_rdata (w_rdata),
        .o_push      (w_push),
        .o_result    (w_push_result),
        .o_status    (w_status)
    );

    smvm_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_push_result),
        .i_pop    (i_m_axis_tready),
        .o_valid  (w_q_valid),
        .o_result (w_q_result),
        .o_count  (w_q_count)
    );

    // Pack the output word
    assign o_m_axis_tvalid = w_q_valid;
    assign o_m_axis_tdata  = {w_q_result.row_sum, w_q_result.row_number};
    assign o_m_axis_tuser  = w_q_result.saturated;

    // Room is reserved for every word in flight
    a_reserve_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_reserved <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result reservation exceeded queue size");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for sparse_matrix_vector_multiply_core.
// Drives vector loads, matrix entries and row closes on the input stream, predicts
// every row result and compares it with the output stream. Depends on smvm_pkg.
`timescale 1ns / 100ps

module tb;
    import smvm_pkg::*;

    localparam int  VEC_DEPTH    = 1024;
    localparam int  RAND_WORDS   = 1200;
    localparam int  TAIL_WORDS   = 150;
    localparam int  LONG_HOLD    = 300;
    localparam int  SETTLE       = 20;
    localparam int  MAX_REPORTS  = 10;
    // Command code the core must ignore
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam longint SUM_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN   = 64'h8000_0000_0000_0000;
    localparam int  VAL_MAX      = 32'h7FFF_FFFF;
    localparam int  VAL_MIN      = 32'h8000_0000;

    typedef struct {
        logic [1:0]  cmd;
        logic [9:0]  col;
        int          val;
        bit          last;
        bit          fixed;
        logic [15:0] f_row;
        longint      f_sum;
        bit          f_sat;
    } dir_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [47:0] in_data = '0;
    logic [1:0]  in_cmd = CMD_LOAD;
    logic        in_last = 1'b0;
    logic        out_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [79:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;

    // Predictor state
    int          vec_mem [VEC_DEPTH];
    bit          col_loaded [VEC_DEPTH];
    int          loaded_cols [$];
    longint      dot_acc;
    bit          dot_sat;
    logic [15:0] row_idx;
    t_result     row_results_due [$];

    int          words_sent;
    int          mismatches = 0;
    int          gap_pct;
    int          recv_gap_pct;
    bit          tail_phase;
    bit          hold_armed;
    t_result     got;
    t_result     want;

    // Directed words: result typed in where it is obvious, otherwise predicted
    dir_word_t dir_rows [23] = '{
        '{CMD_EMPTY_ROW, 10'd0,    0,       1'b0, 1'b1, 16'd0, 64'sd0,         1'b0},
        '{CMD_LOAD,      10'd0,    VAL_MAX, 1'b0, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_LOAD,      10'd1023, VAL_MIN, 1'b1, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_LOAD,      10'd1,    0,       1'b0, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_LOAD,      10'd2,    -1,      1'b0, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_ENTRY,     10'd0,    1,       1'b1, 1'b1, 16'd0, 64'sd2147483647, 1'b0},
        '{CMD_ENTRY,     10'd1023, VAL_MIN, 1'b0, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_ENTRY,     10'd1023, VAL_MIN, 1'b1, 1'b1, 16'd1, SUM_MAX,        1'b1},
        '{CMD_EMPTY_ROW, 10'd0,    0,       1'b0, 1'b1, 16'd2, 64'sd0,         1'b0},
        '{CMD_ENTRY,     10'd0,    VAL_MIN, 1'b0, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_ENTRY,     10'd0,    VAL_MIN, 1'b0, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_ENTRY,     10'd0,    VAL_MIN, 1'b1, 1'b1, 16'd3, SUM_MIN,        1'b1},
        '{CMD_ENTRY,     10'd2,    5,       1'b0, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_SPARE,     10'd1023, VAL_MAX, 1'b1, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_EMPTY_ROW, 10'd0,    0,       1'b1, 1'b1, 16'd4, -64'sd5,        1'b0},
        '{CMD_ENTRY,     10'd1,    VAL_MAX, 1'b0, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_LOAD,      10'd1,    3,       1'b0, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_ENTRY,     10'd1,    -7,      1'b1, 1'b1, 16'd0, -64'sd21,       1'b0},
        '{CMD_ENTRY,     10'd2,    VAL_MAX, 1'b0, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_ENTRY,     10'd0,    VAL_MAX, 1'b1, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_ENTRY,     10'd1023, VAL_MIN, 1'b0, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_ENTRY,     10'd1023, VAL_MIN, 1'b0, 1'b0, 16'd0, 64'sd0,         1'b0},
        '{CMD_ENTRY,     10'd2,    VAL_MAX, 1'b1, 1'b0, 16'd0, 64'sd0,         1'b0}
    };

    sparse_matrix_vector_multiply_core #(
        .VECTOR_DEPTH(VEC_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(in_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (in_data),
        .i_s_axis_tuser (in_cmd),
        .i_s_axis_tlast (in_last),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(out_ready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Advance the row dot product by one accepted word; return 1 when a row closes
    function automatic bit dot_step(input logic [1:0] cmd, input logic [9:0] col,
                                    input int val, input bit last, output t_result res);
        longint prod;
        bit     emit;
        emit = 1'b0;
        res  = '0;
        case (cmd)
            CMD_LOAD: begin
                vec_mem[col] = val;
                if (!col_loaded[col]) begin
                    col_loaded[col] = 1'b1;
                    loaded_cols.push_back(col);
                end
                row_idx = '0;
                dot_acc = 0;
                dot_sat = 1'b0;
            end
            CMD_ENTRY: begin
                prod = longint'(val) * longint'(vec_mem[col]);
                // clamp to the nearest 64-bit limit and keep the flag until the row closes
                if (prod > 0 && dot_acc > SUM_MAX - prod) begin
                    dot_acc = SUM_MAX;
                    dot_sat = 1'b1;
                end else if (prod < 0 && dot_acc < SUM_MIN - prod) begin
                    dot_acc = SUM_MIN;
                    dot_sat = 1'b1;
                end else begin
                    dot_acc = dot_acc + prod;
                end
                emit = last;
            end
            CMD_EMPTY_ROW: emit = 1'b1;
            default: ;
        endcase
        if (emit) begin
            res.row_number = row_idx;
            res.row_sum    = dot_acc;
            res.saturated  = dot_sat;
            dot_acc = 0;
            dot_sat = 1'b0;
            row_idx = row_idx + 16'd1;
        end
        return emit;
    endfunction

    // Mostly random values, with the 32-bit extremes and small numbers mixed in
    function automatic int pick_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return int'($urandom_range(0, 32)) - 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [9:0] pick_loaded_col();
        return 10'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
    endfunction

    // Offer one word, hold it until accepted, then record the row result it closes
    task automatic send_word(input logic [1:0] cmd, input logic [9:0] col, input int val,
                             input bit last, input bit fixed, input t_result fixed_res);
        t_result res;
        bit      has;
        if (!tail_phase && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_data  <= {6'b0, val, col};
        in_last  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        has = dot_step(cmd, col, val, last, res);
        if (has)
            row_results_due.push_back(fixed ? fixed_res : res);
        if (cmd != CMD_SPARE)
            words_sent++;
    endtask

    // Stop offering until every outstanding row result has been seen
    task automatic drain_rows();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (row_results_due.size() != 0) @(posedge i_clk);
    endtask

    // Reset once at the start, then release it
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Output side ready: one long hold-off, random stalls, none in the tail
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!tail_phase && $urandom_range(0, 99) < recv_gap_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && out_ready) begin
            got.row_number = o_m_axis_tdata[15:0];
            got.row_sum    = o_m_axis_tdata[79:16];
            got.saturated  = o_m_axis_tuser[0];
            if (row_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: row %0d sum %0d sat %0b",
                             got.row_number, got.row_sum, got.saturated);
            end else begin
                want = row_results_due.pop_front();
                if (got.row_number !== want.row_number || got.row_sum !== want.row_sum ||
                    got.saturated !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: expected row %0d sum %0d sat %0b, ",
                                  "got row %0d sum %0d sat %0b"},
                                 want.row_number, want.row_sum, want.saturated,
                                 got.row_number, got.row_sum, got.saturated);
                end
            end
        end
    end

    // Stimulus: directed words, then random rows
    initial begin
        t_result    fr;
        int         base;
        int         pick;
        int         n;
        bit         close_by_empty;
        bit         drained_once;
        logic [9:0] col;
        dot_acc      = 0;
        dot_sat      = 1'b0;
        row_idx      = '0;
        words_sent   = 0;
        gap_pct      = 20;
        recv_gap_pct = 10;
        tail_phase   = 1'b0;
        hold_armed   = 1'b0;
        drained_once = 1'b0;
        foreach (vec_mem[k]) begin
            vec_mem[k]    = 0;
            col_loaded[k] = 1'b0;
        end
        while (!i_rst_n) @(posedge i_clk);

        // Directed: extremes, saturation both ways, partial rows, spare command
        foreach (dir_rows[k]) begin
            fr.row_number = dir_rows[k].f_row;
            fr.row_sum    = dir_rows[k].f_sum;
            fr.saturated  = dir_rows[k].f_sat;
            send_word(dir_rows[k].cmd, dir_rows[k].col, dir_rows[k].val, dir_rows[k].last,
                      dir_rows[k].fixed, fr);
        end
        drain_rows();

        // Restart row numbering with one more load
        gap_pct = 0;
        send_word(CMD_LOAD, 10'd3, pick_value(), 1'b0, 1'b0, '0);

        // Random rows, load bursts, broken rows and noise
        base       = words_sent;
        hold_armed = 1'b1;
        while (words_sent < base + RAND_WORDS) begin
            if (words_sent >= base + RAND_WORDS - TAIL_WORDS)
                tail_phase = 1'b1;
            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 40;
                endcase
                recv_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            end
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                repeat ($urandom_range(1, 5))
                    send_word(CMD_LOAD, 10'($urandom), pick_value(), 1'($urandom), 1'b0, '0);
            end else if (pick < 10) begin
                // row cut short by a load
                repeat ($urandom_range(1, 3))
                    send_word(CMD_ENTRY, pick_loaded_col(), pick_value(), 1'b0, 1'b0, '0);
                send_word(CMD_LOAD, 10'($urandom), pick_value(), 1'($urandom), 1'b0, '0);
            end else if (pick < 16) begin
                send_word(CMD_EMPTY_ROW, 10'($urandom), pick_value(), 1'($urandom), 1'b0, '0);
            end else if (pick < 20) begin
                send_word(CMD_SPARE, 10'($urandom), pick_value(), 1'($urandom), 1'b0, '0);
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
                close_by_empty = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < n; k++) begin
                    col = pick_loaded_col();
                    send_word(CMD_ENTRY, col, pick_value(), (k == n - 1) && !close_by_empty,
                              1'b0, '0);
                end
                if (close_by_empty)
                    send_word(CMD_EMPTY_ROW, 10'($urandom), pick_value(), 1'($urandom),
                              1'b0, '0);
            end
            if (!drained_once && words_sent >= base + RAND_WORDS / 2) begin
                drained_once = 1'b1;
                drain_rows();
            end
        end

        // Wait out the pipeline, then judge
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (row_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && row_results_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
